### sv/keepout_zone_velocity_gate_defines.svh
// ----------------------------------------------------------------------------
// Keepout zone velocity gate: assertion macros
// Shared property shapes used by the gate's embedded checks.
// ----------------------------------------------------------------------------
`ifndef KEEPOUT_ZONE_VELOCITY_GATE_DEFINES_SVH
`define KEEPOUT_ZONE_VELOCITY_GATE_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define KZVG_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define KZVG_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/kzvg_pkg.sv
// ----------------------------------------------------------------------------
// Keepout zone velocity gate package
// Widths, register indexes and the structs shared between pipeline parts.
// ----------------------------------------------------------------------------
package kzvg_pkg;

    localparam int POS_W   = 24;              // position and bound width
    localparam int VEL_W   = 18;              // velocity width
    localparam int RID_W   = 4;               // robot index width
    localparam int GID_W   = 5;               // goalie index width
    localparam int IDX_W   = 3;               // config register index width
    localparam int NPOS_W  = POS_W + 1;       // predicted position, bound sums
    localparam int D_W     = POS_W + 2;       // distance to clamped point
    localparam int C_W     = POS_W + 3;       // doubled offset from rectangle centre
    localparam int DSQ_W   = 2 * D_W - 1;     // square of a distance component
    localparam int DIST_W  = DSQ_W + 1;       // sum of two squares
    localparam int CSQ_W   = 2 * C_W - 1;     // square of a centre offset
    localparam int CDIST_W = CSQ_W + 1;       // sum of two centre squares

    localparam logic [IDX_W-1:0] REG_OWN_X_MIN = 3'd0;
    localparam logic [IDX_W-1:0] REG_OWN_X_MAX = 3'd1;
    localparam logic [IDX_W-1:0] REG_OWN_Y_MIN = 3'd2;
    localparam logic [IDX_W-1:0] REG_OWN_Y_MAX = 3'd3;
    localparam logic [IDX_W-1:0] REG_FAR_X_MIN = 3'd4;
    localparam logic [IDX_W-1:0] REG_FAR_X_MAX = 3'd5;
    localparam logic [IDX_W-1:0] REG_FAR_Y_MIN = 3'd6;
    localparam logic [IDX_W-1:0] REG_FAR_Y_MAX = 3'd7;

    // Rectangle bounds as written by software (possibly swapped).
    typedef struct packed {
        logic signed [POS_W-1:0] x_min;
        logic signed [POS_W-1:0] x_max;
        logic signed [POS_W-1:0] y_min;
        logic signed [POS_W-1:0] y_max;
    } bounds_t;

    // Ordered rectangle plus doubled centre coordinates.
    typedef struct packed {
        logic signed [POS_W-1:0]  lo_x;
        logic signed [POS_W-1:0]  hi_x;
        logic signed [POS_W-1:0]  lo_y;
        logic signed [POS_W-1:0]  hi_y;
        logic signed [NPOS_W-1:0] sum_x;
        logic signed [NPOS_W-1:0] sum_y;
    } rect_t;

    // Current and predicted position of one command.
    typedef struct packed {
        logic signed [POS_W-1:0]  px;
        logic signed [POS_W-1:0]  py;
        logic signed [NPOS_W-1:0] nx;
        logic signed [NPOS_W-1:0] ny;
    } motion_t;

    // Fields that ride alongside the geometry unchanged.
    typedef struct packed {
        logic [RID_W-1:0]        rid;
        logic                    present;
        logic signed [VEL_W-1:0] vx;
        logic signed [VEL_W-1:0] vy;
        logic                    active;
    } side_t;

    // Load enables for the geometry stages.
    typedef struct packed {
        logic adv2;
        logic adv3;
        logic adv4;
    } pipe_ctrl_t;

endpackage

### sv/keepout_zone_velocity_gate.sv
// ----------------------------------------------------------------------------
// Keepout zone velocity gate
// Zeroes a robot's commanded velocity when its 10 ms prediction runs into a
// keepout rectangle without moving away from the rectangle's centre.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one motion command per
//   transaction; output channel (out_valid / out_stall) returns exactly one
//   result per command, in order. Both sides hold payload while stalled.
//   Pipeline: a command accepted on the input passes five register stages
//   (predict, clamp, square, sum, decide) before it shows on the output.
//   Throughput: one transaction per cycle while out_stall is low, set by the
//   fully pipelined multipliers (six per rectangle, one stage each).
//   Stall: when out_stall holds a result, stages behind it keep advancing
//   into empty slots; in_stall rises only once every stage is full.
//   Reset: clears all valid bits and sets both rectangles to zero bounds.
//   Configuration: write cfg_data into register cfg_index while cfg_we is
//   high; do so only while no transaction is in flight.
// ----------------------------------------------------------------------------
module keepout_zone_velocity_gate #(
    parameter int ROBOT_RADIUS_UM = 90000
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    // configuration
    input  logic                                   cfg_we,
    input  logic [kzvg_pkg::IDX_W-1:0]             cfg_index,
    input  logic [kzvg_pkg::POS_W-1:0]             cfg_data,
    // input channel
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic [kzvg_pkg::RID_W-1:0]             robot_index,
    input  logic                                   command_present,
    input  logic [kzvg_pkg::GID_W-1:0]             goalie_index,
    input  logic signed [kzvg_pkg::POS_W-1:0]      pos_x,
    input  logic signed [kzvg_pkg::POS_W-1:0]      pos_y,
    input  logic signed [kzvg_pkg::VEL_W-1:0]      vel_x,
    input  logic signed [kzvg_pkg::VEL_W-1:0]      vel_y,
    // output channel
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic [kzvg_pkg::RID_W-1:0]             robot_index_out,
    output logic                                   present_out,
    output logic signed [kzvg_pkg::VEL_W-1:0]      vel_x_out,
    output logic signed [kzvg_pkg::VEL_W-1:0]      vel_y_out,
    output logic                                   blocked
);

`include "keepout_zone_velocity_gate_defines.svh"

    localparam int DIST_W  = kzvg_pkg::DIST_W;
    localparam int DSQ_W   = kzvg_pkg::DSQ_W;
    localparam int VEL_W   = kzvg_pkg::VEL_W;
    localparam longint RADIUS_SQ = longint'(ROBOT_RADIUS_UM) * longint'(ROBOT_RADIUS_UM);
    localparam logic [DIST_W-1:0] RADIUS_SQ_V = DIST_W'(RADIUS_SQ);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    kzvg_pkg::bounds_t own_bounds_reg, far_bounds_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_bounds_reg <= '0;
            far_bounds_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                kzvg_pkg::REG_OWN_X_MIN: own_bounds_reg.x_min <= cfg_data;
                kzvg_pkg::REG_OWN_X_MAX: own_bounds_reg.x_max <= cfg_data;
                kzvg_pkg::REG_OWN_Y_MIN: own_bounds_reg.y_min <= cfg_data;
                kzvg_pkg::REG_OWN_Y_MAX: own_bounds_reg.y_max <= cfg_data;
                kzvg_pkg::REG_FAR_X_MIN: far_bounds_reg.x_min <= cfg_data;
                kzvg_pkg::REG_FAR_X_MAX: far_bounds_reg.x_max <= cfg_data;
                kzvg_pkg::REG_FAR_Y_MIN: far_bounds_reg.y_min <= cfg_data;
                kzvg_pkg::REG_FAR_Y_MAX: far_bounds_reg.y_max <= cfg_data;
                default:                 own_bounds_reg       <= own_bounds_reg;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline flow control: a stage advances when it is empty or the
    // stage after it advances. Valid bits travel with the data.
    // ------------------------------------------------------------------
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg, out_valid_reg;
    logic adv1, adv2, adv3, adv4, adv5;
    kzvg_pkg::pipe_ctrl_t ctrl;

    assign adv5 = !out_valid_reg || !out_stall;
    assign adv4 = !s4_valid_reg || adv5;
    assign adv3 = !s3_valid_reg || adv4;
    assign adv2 = !s2_valid_reg || adv3;
    assign adv1 = !s1_valid_reg || adv2;

    assign ctrl.adv2 = adv2;
    assign ctrl.adv3 = adv3;
    assign ctrl.adv4 = adv4;

    assign in_stall = !adv1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
                s1_valid_reg <= in_valid;
            if (adv2)
                s2_valid_reg <= s1_valid_reg;
            if (adv3)
                s3_valid_reg <= s2_valid_reg;
            if (adv4)
                s4_valid_reg <= s3_valid_reg;
            if (adv5)
                out_valid_reg <= s4_valid_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: prediction and bound ordering
    // ------------------------------------------------------------------
    kzvg_pkg::rect_t   own_rect, far_rect;
    kzvg_pkg::motion_t motion;
    kzvg_pkg::side_t   s1_side;

    kzvg_front u_front (
        .clk             (clk),
        .ce              (adv1),
        .own_bounds      (own_bounds_reg),
        .far_bounds      (far_bounds_reg),
        .robot_index     (robot_index),
        .command_present (command_present),
        .goalie_index    (goalie_index),
        .pos_x           (pos_x),
        .pos_y           (pos_y),
        .vel_x           (vel_x),
        .vel_y           (vel_y),
        .own_rect        (own_rect),
        .far_rect        (far_rect),
        .motion          (motion),
        .side            (s1_side)
    );

    // ------------------------------------------------------------------
    // Stages 2 to 4: one geometry pipeline per rectangle
    // ------------------------------------------------------------------
    logic [DSQ_W-1:0] own_dx_sq, own_dy_sq, far_dx_sq, far_dy_sq;
    logic             own_escape, far_escape;

    kzvg_rect_check u_own_check (
        .clk    (clk),
        .ctrl   (ctrl),
        .rect   (own_rect),
        .motion (motion),
        .dx_sq  (own_dx_sq),
        .dy_sq  (own_dy_sq),
        .escape (own_escape)
    );

    kzvg_rect_check u_far_check (
        .clk    (clk),
        .ctrl   (ctrl),
        .rect   (far_rect),
        .motion (motion),
        .dx_sq  (far_dx_sq),
        .dy_sq  (far_dy_sq),
        .escape (far_escape)
    );

    // Carry the pass-through fields alongside the geometry.
    kzvg_pkg::side_t s2_side_reg, s3_side_reg, s4_side_reg;

    always_ff @(posedge clk)
    begin
        if (adv2)
            s2_side_reg <= s1_side;
        if (adv3)
            s3_side_reg <= s2_side_reg;
        if (adv4)
            s4_side_reg <= s3_side_reg;
    end

    // ------------------------------------------------------------------
    // Stage 5: contact test and decision into the output register.
    // The first rectangle wins whenever the disk touches it.
    // ------------------------------------------------------------------
    logic [DIST_W-1:0] own_dist, far_dist;
    logic              own_touch, far_touch, blocked_next;
    logic [kzvg_pkg::RID_W-1:0] rid_out_reg;
    logic              present_out_reg, blocked_reg;
    logic signed [VEL_W-1:0] vel_x_out_reg, vel_x_out_next;
    logic signed [VEL_W-1:0] vel_y_out_reg, vel_y_out_next;

    assign own_dist  = DIST_W'(own_dx_sq) + DIST_W'(own_dy_sq);
    assign far_dist  = DIST_W'(far_dx_sq) + DIST_W'(far_dy_sq);
    assign own_touch = own_dist <= RADIUS_SQ_V;
    assign far_touch = far_dist <= RADIUS_SQ_V;

    always_comb
    begin
        if (!s4_side_reg.active)
            blocked_next = 1'b0;
        else if (own_touch)
            blocked_next = !own_escape;
        else
            blocked_next = far_touch && !far_escape;
        // Drop the velocity when blocked.
        vel_x_out_next = blocked_next ? '0 : s4_side_reg.vx;
        vel_y_out_next = blocked_next ? '0 : s4_side_reg.vy;
    end

    always_ff @(posedge clk)
    begin
        if (adv5)
        begin
            rid_out_reg     <= s4_side_reg.rid;
            present_out_reg <= s4_side_reg.present;
            vel_x_out_reg   <= vel_x_out_next;
            vel_y_out_reg   <= vel_y_out_next;
            blocked_reg     <= blocked_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign robot_index_out = rid_out_reg;
    assign present_out     = present_out_reg;
    assign vel_x_out       = vel_x_out_reg;
    assign vel_y_out       = vel_y_out_reg;
    assign blocked         = blocked_reg;

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    `KZVG_ASSERT_NOW(a_blocked_zero_vel, out_valid_reg && blocked_reg,
                     vel_x_out_reg == '0 && vel_y_out_reg == '0,
                     "blocked result carries nonzero velocity")
    `KZVG_ASSERT_NOW(a_blocked_present, out_valid_reg && blocked_reg, present_out_reg,
                     "absent command reported as blocked")
    `KZVG_ASSERT_NEXT(a_s4_held, s4_valid_reg && !adv5, s4_valid_reg,
                      "stage 4 transaction lost under output stall")

endmodule

### sv/kzvg_front.sv
// ----------------------------------------------------------------------------
// Keepout zone velocity gate: front stage
// Predicts the position 10 ms ahead, orders the bounds and flags checked items.
// ----------------------------------------------------------------------------
module kzvg_front (
    input  logic                                   clk,
    input  logic                                   ce,
    input  kzvg_pkg::bounds_t                      own_bounds,
    input  kzvg_pkg::bounds_t                      far_bounds,
    input  logic [kzvg_pkg::RID_W-1:0]             robot_index,
    input  logic                                   command_present,
    input  logic [kzvg_pkg::GID_W-1:0]             goalie_index,
    input  logic signed [kzvg_pkg::POS_W-1:0]      pos_x,
    input  logic signed [kzvg_pkg::POS_W-1:0]      pos_y,
    input  logic signed [kzvg_pkg::VEL_W-1:0]      vel_x,
    input  logic signed [kzvg_pkg::VEL_W-1:0]      vel_y,
    output kzvg_pkg::rect_t                        own_rect,
    output kzvg_pkg::rect_t                        far_rect,
    output kzvg_pkg::motion_t                      motion,
    output kzvg_pkg::side_t                        side
);

    kzvg_pkg::rect_t   own_rect_reg, own_rect_next;
    kzvg_pkg::rect_t   far_rect_reg, far_rect_next;
    kzvg_pkg::motion_t motion_reg, motion_next;
    kzvg_pkg::side_t   side_reg, side_next;

    // Order both axis pairs and form the doubled centre.
    function automatic kzvg_pkg::rect_t order_rect(input kzvg_pkg::bounds_t b);
        kzvg_pkg::rect_t r;
        if ($signed(b.x_min) > $signed(b.x_max))
        begin
            r.lo_x = b.x_max;
            r.hi_x = b.x_min;
        end
        else
        begin
            r.lo_x = b.x_min;
            r.hi_x = b.x_max;
        end
        if ($signed(b.y_min) > $signed(b.y_max))
        begin
            r.lo_y = b.y_max;
            r.hi_y = b.y_min;
        end
        else
        begin
            r.lo_y = b.y_min;
            r.hi_y = b.y_max;
        end
        r.sum_x = kzvg_pkg::NPOS_W'($signed(b.x_min)) + kzvg_pkg::NPOS_W'($signed(b.x_max));
        r.sum_y = kzvg_pkg::NPOS_W'($signed(b.y_min)) + kzvg_pkg::NPOS_W'($signed(b.y_max));
        return r;
    endfunction

    always_comb
    begin
        own_rect_next     = order_rect(own_bounds);
        far_rect_next     = order_rect(far_bounds);
        motion_next.px    = pos_x;
        motion_next.py    = pos_y;
        motion_next.nx    = kzvg_pkg::NPOS_W'(pos_x) + kzvg_pkg::NPOS_W'(vel_x);
        motion_next.ny    = kzvg_pkg::NPOS_W'(pos_y) + kzvg_pkg::NPOS_W'(vel_y);
        side_next.rid     = robot_index;
        side_next.present = command_present;
        side_next.vx      = vel_x;
        side_next.vy      = vel_y;
        side_next.active  = command_present && ({1'b0, robot_index} != goalie_index);
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            own_rect_reg <= own_rect_next;
            far_rect_reg <= far_rect_next;
            motion_reg   <= motion_next;
            side_reg     <= side_next;
        end
    end

    assign own_rect = own_rect_reg;
    assign far_rect = far_rect_reg;
    assign motion   = motion_reg;
    assign side     = side_reg;

endmodule

### sv/kzvg_rect_check.sv
// ----------------------------------------------------------------------------
// Keepout zone velocity gate: rectangle check pipeline
// Three stages: clamp and centre offsets, differences and squares, sums.
// ----------------------------------------------------------------------------
module kzvg_rect_check (
    input  logic                               clk,
    input  kzvg_pkg::pipe_ctrl_t               ctrl,
    input  kzvg_pkg::rect_t                    rect,
    input  kzvg_pkg::motion_t                  motion,
    output logic [kzvg_pkg::DSQ_W-1:0]         dx_sq,
    output logic [kzvg_pkg::DSQ_W-1:0]         dy_sq,
    output logic                               escape
);

    localparam int NPOS_W  = kzvg_pkg::NPOS_W;
    localparam int D_W     = kzvg_pkg::D_W;
    localparam int C_W     = kzvg_pkg::C_W;
    localparam int DSQ_W   = kzvg_pkg::DSQ_W;
    localparam int CSQ_W   = kzvg_pkg::CSQ_W;
    localparam int CDIST_W = kzvg_pkg::CDIST_W;

    // Stage 2: clamp predicted point into the rectangle, offsets from centre
    logic signed [NPOS_W-1:0] lo_x, hi_x, lo_y, hi_y;
    logic signed [NPOS_W-1:0] s2_nx_reg, s2_nx_next, s2_ny_reg, s2_ny_next;
    logic signed [NPOS_W-1:0] s2_cx_reg, s2_cx_next, s2_cy_reg, s2_cy_next;
    logic signed [C_W-1:0]    s2_ax_reg, s2_ax_next, s2_ay_reg, s2_ay_next;
    logic signed [C_W-1:0]    s2_bx_reg, s2_bx_next, s2_by_reg, s2_by_next;

    // Stage 3: distance to clamped point, squared centre offsets
    logic signed [D_W-1:0]    s3_dx_reg, s3_dx_next, s3_dy_reg, s3_dy_next;
    logic signed [2*C_W-1:0]  ax_prod, ay_prod, bx_prod, by_prod;
    logic [CSQ_W-1:0]         s3_ax_sq_reg, s3_ay_sq_reg, s3_bx_sq_reg, s3_by_sq_reg;

    // Stage 4: squared distances, escape compare
    logic signed [2*D_W-1:0]  dx_prod, dy_prod;
    logic [CDIST_W-1:0]       old_dist, new_dist;
    logic [DSQ_W-1:0]         s4_dx_sq_reg, s4_dy_sq_reg;
    logic                     s4_escape_reg, s4_escape_next;

    always_comb
    begin
        lo_x = NPOS_W'($signed(rect.lo_x));
        hi_x = NPOS_W'($signed(rect.hi_x));
        lo_y = NPOS_W'($signed(rect.lo_y));
        hi_y = NPOS_W'($signed(rect.hi_y));
        s2_nx_next = $signed(motion.nx);
        s2_ny_next = $signed(motion.ny);
        if (s2_nx_next < lo_x)
            s2_cx_next = lo_x;
        else if (s2_nx_next > hi_x)
            s2_cx_next = hi_x;
        else
            s2_cx_next = s2_nx_next;
        if (s2_ny_next < lo_y)
            s2_cy_next = lo_y;
        else if (s2_ny_next > hi_y)
            s2_cy_next = hi_y;
        else
            s2_cy_next = s2_ny_next;
        s2_ax_next = (C_W'($signed(motion.px)) <<< 1) - C_W'($signed(rect.sum_x));
        s2_ay_next = (C_W'($signed(motion.py)) <<< 1) - C_W'($signed(rect.sum_y));
        s2_bx_next = (C_W'(s2_nx_next) <<< 1) - C_W'($signed(rect.sum_x));
        s2_by_next = (C_W'(s2_ny_next) <<< 1) - C_W'($signed(rect.sum_y));
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.adv2)
        begin
            s2_nx_reg <= s2_nx_next;
            s2_ny_reg <= s2_ny_next;
            s2_cx_reg <= s2_cx_next;
            s2_cy_reg <= s2_cy_next;
            s2_ax_reg <= s2_ax_next;
            s2_ay_reg <= s2_ay_next;
            s2_bx_reg <= s2_bx_next;
            s2_by_reg <= s2_by_next;
        end
    end

    assign s3_dx_next = D_W'(s2_nx_reg) - D_W'(s2_cx_reg);
    assign s3_dy_next = D_W'(s2_ny_reg) - D_W'(s2_cy_reg);
    assign ax_prod    = s2_ax_reg * s2_ax_reg;
    assign ay_prod    = s2_ay_reg * s2_ay_reg;
    assign bx_prod    = s2_bx_reg * s2_bx_reg;
    assign by_prod    = s2_by_reg * s2_by_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.adv3)
        begin
            s3_dx_reg    <= s3_dx_next;
            s3_dy_reg    <= s3_dy_next;
            s3_ax_sq_reg <= ax_prod[CSQ_W-1:0];
            s3_ay_sq_reg <= ay_prod[CSQ_W-1:0];
            s3_bx_sq_reg <= bx_prod[CSQ_W-1:0];
            s3_by_sq_reg <= by_prod[CSQ_W-1:0];
        end
    end

    assign dx_prod  = s3_dx_reg * s3_dx_reg;
    assign dy_prod  = s3_dy_reg * s3_dy_reg;
    assign old_dist = CDIST_W'(s3_ax_sq_reg) + CDIST_W'(s3_ay_sq_reg);
    assign new_dist = CDIST_W'(s3_bx_sq_reg) + CDIST_W'(s3_by_sq_reg);
    // Equal distance counts as not escaping.
    assign s4_escape_next = old_dist < new_dist;

    always_ff @(posedge clk)
    begin
        if (ctrl.adv4)
        begin
            s4_dx_sq_reg  <= dx_prod[DSQ_W-1:0];
            s4_dy_sq_reg  <= dy_prod[DSQ_W-1:0];
            s4_escape_reg <= s4_escape_next;
        end
    end

    assign dx_sq  = s4_dx_sq_reg;
    assign dy_sq  = s4_dy_sq_reg;
    assign escape = s4_escape_reg;

endmodule
